>>> src/assert_macros.svh
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> src/ldrs_pkg.sv
// types and constants of the led driver refresh sequencer
package ldrs_pkg;

    // most bus commands one event may cause
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // configuration register indexes
    localparam logic [2:0] REG_ADDR_FIRST  = 3'd0;
    localparam logic [2:0] REG_ADDR_SECOND = 3'd1;
    localparam logic [2:0] REG_ADDR_THIRD  = 3'd2;
    localparam logic [2:0] REG_DUTY_BASE   = 3'd3;
    localparam logic [2:0] REG_UPDATE      = 3'd4;

    // input events
    typedef enum logic [2:0] {
        OP_START       = 3'd0,
        OP_STOP        = 3'd1,
        OP_FIFO_LOW    = 3'd2,
        OP_NACK        = 3'd3,
        OP_STORE_WRITE = 3'd4
    } op_t;

    // bus commands
    typedef enum logic [2:0] {
        CMD_ADDR  = 3'd0,
        CMD_PUSH  = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_DONE  = 3'd4,
        CMD_NACK  = 3'd5
    } cmd_t;

    // refresh mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_UPDATE = 2'd2
    } mode_t;

endpackage

>>> src/led_driver_refresh_sequencer_core.sv
// led driver refresh sequencer: event decoder, command sequencer and frame store
//
// Input channel (in_valid / in_stall) takes one event per transfer: start, stop
// detected, fifo low, nack or frame store write. The block stalls its input while
// it works off an event, and takes the next one once the last command of the
// current event sits in the output register.
// Output channel (out_valid / out_stall) gives the bus commands in order, one per
// transfer, with last marking the final command of the event. Events that cause
// no command (frame store writes, stops and fifo lows while idle) give nothing.
// The commands of an event follow one a cycle while the output does not stall,
// save where a fill step pushes no byte. One shared sequencer issues every
// command, and the frame store has one registered read port.
// A stall on a valid output holds the output register and the sequencer in any state that emits.
// Configuration writes are taken at any cycle through cfg_write.
// Reset: mode idle, pointers and device index zero, registers at their defaults,
// and every frame store entry reads as zero until written.
`include "assert_macros.svh"

module led_driver_refresh_sequencer_core #(
    parameter int CHANNELS   = 25,
    parameter int DEVICES    = 3,
    parameter int FIFO_SLOTS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // event input
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [2:0] fifo_level,
    input  logic [6:0] pixel_index,
    input  logic [7:0] pixel_value,
    // command output
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] command,
    output logic [7:0] command_value,
    output logic       last
);

    import ldrs_pkg::*;

    localparam int DEPTH = CHANNELS * DEVICES;
    localparam int PTR_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(FIFO_SLOTS + MAX_RESULTS + 8);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ADDR  = 9'b000000010,
        S_BASE  = 9'b000000100,
        S_ZERO  = 9'b000001000,
        S_FILL  = 9'b000010000,
        S_START = 9'b000100000,
        S_STOP  = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_NACK  = 9'b100000000
    } state_t;

    // configuration registers
    logic [6:0] addr_first_reg, addr_second_reg, addr_third_reg;
    logic [7:0] duty_base_reg, update_addr_reg;

    // sequencer state
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [1:0]         dev_reg, dev_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   ep_reg, ep_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               tail_start_reg, tail_start_next;

    // frame store
    logic [7:0]         frame_store_reg [DEPTH];
    logic [DEPTH-1:0]   stored_reg;
    logic [7:0]         rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_in_range;
    logic [IDX_W-1:0]   rd_addr;
    logic               store_we;
    logic [IDX_W-1:0]   wr_addr;

    // output register
    logic               out_valid_reg;
    cmd_t               cmd_reg;
    logic [7:0]         val_reg;
    logic               last_reg;

    // emit request from the sequencer
    logic               emit_en;
    cmd_t               emit_cmd;
    logic [7:0]         emit_val;
    logic               emit_last;
    logic               emit_fire;
    logic               out_free;
    logic               in_accept;

    // fill step terms
    logic [PTR_W-1:0]   rp_inc;
    logic [LVL_W-1:0]   level_inc;
    logic [CNT_W-1:0]   cnt_inc;
    logic               fill_go;
    logic               fill_cont;
    logic [1:0]         dev_inc;
    logic [6:0]         dev_addr;
    logic [7:0]         pixel_byte;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = emit_en && out_free;

    assign rp_inc    = rp_reg + PTR_W'(1);
    assign level_inc = level_reg + LVL_W'(1);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign dev_inc   = dev_reg + 2'd1;

    assign fill_go   = (level_reg < LVL_W'(FIFO_SLOTS)) && (rp_reg < ep_reg)
                    && (cnt_reg < CNT_W'(MAX_RESULTS - 1));
    assign fill_cont = (level_inc < LVL_W'(FIFO_SLOTS)) && (rp_inc < ep_reg)
                    && (cnt_inc < CNT_W'(MAX_RESULTS - 1));

    assign pixel_byte = rd_valid_reg ? rd_data_reg : 8'd0;

    // bus address of the current device
    always_comb
    begin
        case (dev_reg)
            2'd0:    dev_addr = addr_first_reg;
            2'd1:    dev_addr = addr_second_reg;
            default: dev_addr = addr_third_reg;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_first_reg  <= 7'd60;
            addr_second_reg <= 7'd63;
            addr_third_reg  <= 7'd61;
            duty_base_reg   <= 8'd5;
            update_addr_reg <= 8'd37;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ADDR_FIRST:  addr_first_reg  <= cfg_data[6:0];
                REG_ADDR_SECOND: addr_second_reg <= cfg_data[6:0];
                REG_ADDR_THIRD:  addr_third_reg  <= cfg_data[6:0];
                REG_DUTY_BASE:   duty_base_reg   <= cfg_data;
                REG_UPDATE:      update_addr_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer next state and emitted command
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        dev_next        = dev_reg;
        rp_next         = rp_reg;
        ep_next         = ep_reg;
        level_next      = level_reg;
        cnt_next        = cnt_reg;
        tail_start_next = tail_start_reg;
        emit_en         = 1'b0;
        emit_cmd        = CMD_ADDR;
        emit_val        = 8'd0;
        emit_last       = 1'b0;
        store_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    level_next = LVL_W'(fifo_level);
                    cnt_next   = '0;
                    case (operation)
                        OP_START:
                        begin
                            mode_next       = MODE_WRITE;
                            dev_next        = 2'd0;
                            rp_next         = '0;
                            ep_next         = PTR_W'(CHANNELS);
                            tail_start_next = 1'b1;
                            state_next      = S_ADDR;
                        end
                        OP_STOP:
                        begin
                            if (mode_reg == MODE_WRITE)
                            begin
                                tail_start_next = 1'b1;
                                state_next      = S_ADDR;
                                if (32'(dev_inc) < DEVICES)
                                begin
                                    dev_next = dev_inc;
                                    ep_next  = ep_reg + PTR_W'(CHANNELS);
                                end
                                else
                                begin
                                    dev_next  = 2'd0;
                                    mode_next = MODE_UPDATE;
                                end
                            end
                            else if (mode_reg == MODE_UPDATE)
                            begin
                                tail_start_next = 1'b1;
                                if (32'(dev_inc) < DEVICES)
                                begin
                                    dev_next   = dev_inc;
                                    state_next = S_ADDR;
                                end
                                else
                                begin
                                    mode_next  = MODE_WRITE;
                                    dev_next   = 2'd0;
                                    rp_next    = '0;
                                    ep_next    = PTR_W'(CHANNELS);
                                    state_next = S_DONE;
                                end
                            end
                        end
                        OP_FIFO_LOW:
                        begin
                            if (mode_reg == MODE_WRITE)
                            begin
                                tail_start_next = 1'b0;
                                state_next      = S_FILL;
                            end
                            else if (mode_reg == MODE_UPDATE)
                            begin
                                state_next = S_STOP;
                            end
                        end
                        OP_NACK:
                        begin
                            mode_next  = MODE_IDLE;
                            state_next = S_NACK;
                        end
                        OP_STORE_WRITE:
                        begin
                            store_we = ({1'b0, pixel_index} < 8'(DEPTH));
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE:
            begin
                emit_en  = 1'b1;
                emit_cmd = CMD_DONE;
                if (out_free)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                emit_en  = 1'b1;
                emit_cmd = CMD_ADDR;
                emit_val = {1'b0, dev_addr};
                if (out_free)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                emit_en  = 1'b1;
                emit_cmd = CMD_PUSH;
                emit_val = (mode_reg == MODE_UPDATE) ? update_addr_reg : duty_base_reg;
                if (out_free)
                begin
                    level_next = level_inc;
                    state_next = (mode_reg == MODE_UPDATE) ? S_ZERO : S_FILL;
                end
            end
            S_ZERO:
            begin
                emit_en  = 1'b1;
                emit_cmd = CMD_PUSH;
                if (out_free)
                begin
                    level_next = level_inc;
                    state_next = S_START;
                end
            end
            S_FILL:
            begin
                if (fill_go)
                begin
                    emit_en   = 1'b1;
                    emit_cmd  = CMD_PUSH;
                    emit_val  = pixel_byte;
                    emit_last = !tail_start_reg && !fill_cont && (rp_inc < ep_reg);
                    if (out_free)
                    begin
                        rp_next    = rp_inc;
                        level_next = level_inc;
                        if (fill_cont)
                        begin
                            state_next = S_FILL;
                        end
                        else if (tail_start_reg)
                        begin
                            state_next = S_START;
                        end
                        else if (rp_inc >= ep_reg)
                        begin
                            state_next = S_STOP;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                // nothing to push: go straight to the closing command, or back to idle if none is due
                else if (tail_start_reg)
                begin
                    state_next = S_START;
                end
                else if (rp_reg >= ep_reg)
                begin
                    state_next = S_STOP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_START:
            begin
                emit_en   = 1'b1;
                emit_cmd  = CMD_START;
                emit_last = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STOP:
            begin
                emit_en   = 1'b1;
                emit_cmd  = CMD_STOP;
                emit_last = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_NACK:
            begin
                emit_en   = 1'b1;
                emit_cmd  = CMD_NACK;
                emit_last = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_fire)
        begin
            cnt_next = cnt_inc;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_IDLE;
            dev_reg        <= 2'd0;
            rp_reg         <= '0;
            ep_reg         <= '0;
            level_reg      <= '0;
            cnt_reg        <= '0;
            tail_start_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            dev_reg        <= dev_next;
            rp_reg         <= rp_next;
            ep_reg         <= ep_next;
            level_reg      <= level_next;
            cnt_reg        <= cnt_next;
            tail_start_reg <= tail_start_next;
        end
    end

    // frame store addressing
    assign wr_addr     = IDX_W'(pixel_index);
    assign rd_in_range = (rp_next < PTR_W'(DEPTH));
    assign rd_addr     = rd_in_range ? IDX_W'(rp_next) : '0;

    // frame store memory with registered read at the next read pointer
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            frame_store_reg[wr_addr] <= pixel_value;
        end
        rd_data_reg <= frame_store_reg[rd_addr];
    end

    // written marks, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (store_we)
            begin
                stored_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= rd_in_range && stored_reg[rd_addr];
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            cmd_reg  <= emit_cmd;
            val_reg  <= emit_val;
            last_reg <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = cmd_reg;
    assign command_value = val_reg;
    assign last          = last_reg;

    // checks on the sequencer
    `ASSERT_NEVER(a_rp_past_end, clk, rst_n, rp_reg > ep_reg, "read pointer beyond end pointer")
    `ASSERT_NEVER(a_end_past_store, clk, rst_n, ep_reg > PTR_W'(DEPTH), "end pointer beyond store")
    `ASSERT_NEXT(a_last_ends_event, clk, rst_n, emit_fire && emit_last,
        state_reg == S_IDLE, "event continues after last command")
    `ASSERT_NEXT(a_more_follows, clk, rst_n, emit_fire && !emit_last,
        state_reg != S_IDLE, "event ends without last command")

endmodule

>>> verif/ldrs_command_checker.sv
`timescale 1ns / 1ps
// command checker: predicts the bus commands of each event and compares the output transfers
module ldrs_command_checker #(
    parameter int CHANNELS   = 25,
    parameter int DEVICES    = 3,
    parameter int FIFO_SLOTS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] operation,
    input  logic [2:0] fifo_level,
    input  logic [6:0] pixel_index,
    input  logic [7:0] pixel_value,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] command,
    input  logic [7:0] command_value,
    input  logic       last,
    output int         cmd_errors,
    output int         cmds_due
);
    import ldrs_pkg::*;

    localparam int STORE_DEPTH = CHANNELS * DEVICES;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] value;
        logic       last;
    } bus_cmd_t;

    // shadow configuration
    logic [6:0] addr_first;
    logic [6:0] addr_second;
    logic [6:0] addr_third;
    logic [7:0] duty_base;
    logic [7:0] update_addr;

    // shadow sequencer state
    mode_t      mode;
    int         dev;
    int         rd_ptr;
    int         end_ptr;
    logic [7:0] pixels [STORE_DEPTH];

    // commands of the event being worked out, and the ones still owed by the block
    bus_cmd_t   event_cmds [MAX_RESULTS];
    int         n_cmds;
    int         fifo_fill;
    bus_cmd_t   bus_cmds_due [$];
    int         errors;

    task automatic add_cmd(input cmd_t c, input logic [7:0] v);
        if (n_cmds < MAX_RESULTS)
        begin
            event_cmds[n_cmds].command = c;
            event_cmds[n_cmds].value   = v;
            event_cmds[n_cmds].last    = 1'b0;
            n_cmds++;
        end
    endtask

    task automatic push_byte(input logic [7:0] v);
        add_cmd(CMD_PUSH, v);
        fifo_fill++;
    endtask

    function automatic logic [6:0] device_addr(input int d);
        if (d == 0)
            return addr_first;
        if (d == 1)
            return addr_second;
        return addr_third;
    endfunction

    // top up the fifo from the frame store, keeping room in the event for the closing command
    task automatic fill_fifo();
        while (fifo_fill < FIFO_SLOTS && rd_ptr < end_ptr && n_cmds < MAX_RESULTS - 1)
        begin
            push_byte(rd_ptr < STORE_DEPTH ? pixels[rd_ptr] : 8'd0);
            rd_ptr++;
        end
    endtask

    task automatic open_write();
        add_cmd(CMD_ADDR, {1'b0, device_addr(dev)});
        push_byte(duty_base);
        fill_fifo();
        add_cmd(CMD_START, 8'd0);
    endtask

    task automatic open_update();
        add_cmd(CMD_ADDR, {1'b0, device_addr(dev)});
        push_byte(update_addr);
        push_byte(8'd0);
        add_cmd(CMD_START, 8'd0);
    endtask

    task automatic restart_frame();
        mode    = MODE_WRITE;
        dev     = 0;
        rd_ptr  = 0;
        end_ptr = CHANNELS;
    endtask

    // work out the commands one event causes and queue them
    task automatic sequence_event(input logic [2:0] op, input logic [2:0] lvl,
                                  input logic [6:0] idx, input logic [7:0] val);
        bus_cmd_t c;
        n_cmds    = 0;
        fifo_fill = lvl;
        case (op)
            OP_START:
            begin
                restart_frame();
                open_write();
            end
            OP_STOP:
            begin
                if (mode == MODE_WRITE)
                begin
                    dev++;
                    if (dev < DEVICES)
                    begin
                        end_ptr += CHANNELS;
                        open_write();
                    end
                    else
                    begin
                        dev  = 0;
                        mode = MODE_UPDATE;
                        open_update();
                    end
                end
                else if (mode == MODE_UPDATE)
                begin
                    dev++;
                    if (dev < DEVICES)
                        open_update();
                    else
                    begin
                        restart_frame();
                        add_cmd(CMD_DONE, 8'd0);
                        open_write();
                    end
                end
            end
            OP_FIFO_LOW:
            begin
                if (mode == MODE_WRITE)
                begin
                    fill_fifo();
                    if (rd_ptr >= end_ptr)
                        add_cmd(CMD_STOP, 8'd0);
                end
                else if (mode == MODE_UPDATE)
                    add_cmd(CMD_STOP, 8'd0);
            end
            OP_NACK:
            begin
                add_cmd(CMD_NACK, 8'd0);
                mode = MODE_IDLE;
            end
            OP_STORE_WRITE:
            begin
                // entries past the store are dropped
                if (idx < STORE_DEPTH)
                    pixels[idx] = val;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < n_cmds; i++)
        begin
            c      = event_cmds[i];
            c.last = (i == n_cmds - 1);
            bus_cmds_due.push_back(c);
        end
    endtask

    task automatic flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // watch both channels and the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        bus_cmd_t want;
        if (!rst_n)
        begin
            addr_first  = 7'd60;
            addr_second = 7'd63;
            addr_third  = 7'd61;
            duty_base   = 8'd5;
            update_addr = 8'd37;
            mode        = MODE_IDLE;
            dev         = 0;
            rd_ptr      = 0;
            end_ptr     = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
                pixels[i] = 8'd0;
            bus_cmds_due.delete();
            errors      = 0;
            cmd_errors <= 0;
            cmds_due   <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ADDR_FIRST:  addr_first  = cfg_data[6:0];
                    REG_ADDR_SECOND: addr_second = cfg_data[6:0];
                    REG_ADDR_THIRD:  addr_third  = cfg_data[6:0];
                    REG_DUTY_BASE:   duty_base   = cfg_data;
                    REG_UPDATE:      update_addr = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && !in_stall)
                sequence_event(operation, fifo_level, pixel_index, pixel_value);

            // compare each command transfer with the oldest one owed
            if (out_valid && !out_stall)
            begin
                if (bus_cmds_due.size() == 0)
                    flag($sformatf("unexpected command %0d value %0d last %0b",
                                   command, command_value, last));
                else
                begin
                    want = bus_cmds_due.pop_front();
                    if (command !== want.command || command_value !== want.value ||
                        last !== want.last)
                        flag($sformatf("command mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                       want.command, want.value, want.last,
                                       command, command_value, last));
                end
            end

            cmd_errors <= errors;
            cmds_due   <= bus_cmds_due.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, event stimulus, configuration phases and verdict
module tb;
    import ldrs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_write     = 1'b0;
    logic [2:0] cfg_index     = REG_ADDR_FIRST;
    logic [7:0] cfg_data      = 8'd0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [2:0] operation     = OP_START;
    logic [2:0] fifo_level    = 3'd0;
    logic [6:0] pixel_index   = 7'd0;
    logic [7:0] pixel_value   = 8'd0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [2:0] command;
    logic [7:0] command_value;
    logic       last;

    int         cmd_errors;
    int         cmds_due;
    int         cycles        = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         events_sent   = 0;
    int         frame_budget;
    bit         frame_broken;

    led_driver_refresh_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .fifo_level    (fifo_level),
        .pixel_index   (pixel_index),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .command_value (command_value),
        .last          (last)
    );

    ldrs_command_checker cmd_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .fifo_level    (fifo_level),
        .pixel_index   (pixel_index),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .command_value (command_value),
        .last          (last),
        .cmd_errors    (cmd_errors),
        .cmds_due      (cmds_due)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one event transfer, with random idle cycles ahead of it
    task automatic send_event(input logic [2:0] op, input logic [2:0] lvl,
                              input logic [6:0] idx, input logic [7:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        fifo_level  <= lvl;
        pixel_index <= idx;
        pixel_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op <= OP_STORE_WRITE)
            events_sent++;
    endtask

    // hold the sender until every owed command has come, then let the block settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cmds_due != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [6:0] a0, input logic [6:0] a1, input logic [6:0] a2,
                              input logic [7:0] duty, input logic [7:0] upd);
        put_reg(REG_ADDR_FIRST, {1'b0, a0});
        put_reg(REG_ADDR_SECOND, {1'b0, a1});
        put_reg(REG_ADDR_THIRD, {1'b0, a2});
        put_reg(REG_DUTY_BASE, duty);
        put_reg(REG_UPDATE, upd);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [2:0] pick_level();
        if ($urandom_range(0, 9) == 0)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    task automatic noise_event();
        send_event(3'($urandom), 3'($urandom), 7'($urandom), 8'($urandom));
    endtask

    // frame event; once the budget runs out the frame is broken by a nack or a restart
    task automatic frame_event(input logic [2:0] op);
        if (!frame_broken)
        begin
            if (frame_budget == 0)
            begin
                frame_broken = 1'b1;
                if ($urandom_range(0, 1) == 0)
                    send_event(OP_NACK, pick_level(), 7'($urandom), 8'($urandom));
                else
                    send_event(OP_START, pick_level(), 7'($urandom), 8'($urandom));
            end
            else
            begin
                frame_budget--;
                if ($urandom_range(0, 5) == 0)
                    send_event(OP_STORE_WRITE, 3'($urandom), 7'($urandom_range(0, 74)),
                               8'($urandom));
                send_event(op, pick_level(), 7'($urandom), 8'($urandom));
            end
        end
    endtask

    // write pass over all devices, then the update pass
    task automatic run_frame();
        frame_broken = 1'b0;
        frame_budget = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 1000;
        frame_event(OP_START);
        for (int d = 0; d < 3; d++)
        begin
            repeat ($urandom_range(2, 6)) frame_event(OP_FIFO_LOW);
            frame_event(OP_STOP);
        end
        for (int d = 0; d < 3; d++)
        begin
            frame_event(OP_FIFO_LOW);
            frame_event(OP_STOP);
        end
    endtask

    task automatic run_phase();
        int target;
        int pick;
        target = events_sent + 10;
        while (events_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                run_frame();
            else if (pick < 9)
                noise_event();
            else
                wait_drain();
        end
    endtask

    initial
    begin
        int send_idle [4];
        int recv_stall [4];
        send_idle  = '{0, 58, 0, 24};
        recv_stall = '{0, 0, 58, 24};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed events at the reset configuration
        send_event(OP_FIFO_LOW, 3'd7, 7'd0, 8'd0);
        send_event(OP_STOP, 3'd0, 7'd127, 8'd255);
        send_event(OP_STORE_WRITE, 3'd0, 7'd0, 8'd255);
        send_event(OP_STORE_WRITE, 3'd0, 7'd74, 8'd0);
        send_event(OP_STORE_WRITE, 3'd0, 7'd24, 8'd128);
        send_event(OP_STORE_WRITE, 3'd0, 7'd127, 8'd170);
        send_event(OP_STORE_WRITE, 3'd0, 7'd75, 8'd85);
        for (int code = OP_STORE_WRITE + 1; code < 8; code++)
            send_event(3'(code), 3'd7, 7'd1, 8'd1);
        send_event(OP_START, 3'd0, 7'd0, 8'd0);
        send_event(OP_FIFO_LOW, 3'd4, 7'd0, 8'd0);
        send_event(OP_FIFO_LOW, 3'd0, 7'd0, 8'd0);
        send_event(OP_STOP, 3'd3, 7'd0, 8'd0);
        send_event(OP_START, 3'd2, 7'd0, 8'd0);
        send_event(OP_STOP, 3'd0, 7'd0, 8'd0);
        send_event(OP_STOP, 3'd0, 7'd0, 8'd0);
        send_event(OP_FIFO_LOW, 3'd6, 7'd0, 8'd0);
        send_event(OP_STOP, 3'd0, 7'd0, 8'd0);
        send_event(OP_STOP, 3'd0, 7'd0, 8'd0);
        send_event(OP_FIFO_LOW, 3'd1, 7'd0, 8'd0);
        send_event(OP_NACK, 3'd0, 7'd0, 8'd0);
        send_event(OP_FIFO_LOW, 3'd5, 7'd0, 8'd0);
        wait_drain();

        // random phases, each under its own configuration and idling mix
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_regs(7'd0, 7'd0, 7'd0, 8'd0, 8'd0);
                1: write_regs(7'd127, 7'd127, 7'd127, 8'd255, 8'd255);
                2: write_regs(7'($urandom), 7'($urandom), 7'($urandom), 8'($urandom),
                              8'($urandom));
                default: write_regs(7'd60, 7'd63, 7'd61, 8'd5, 8'd37);
            endcase
            send_idle_pct = send_idle[p];
            stall_pct     = recv_stall[p];
            run_phase();
            wait_drain();
        end

        if (cmd_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ldrs_pkg.sv
src/led_driver_refresh_sequencer_core.sv
verif/ldrs_command_checker.sv
verif/tb.sv
